// ----- hw/rtl/ddpf_pkg.sv -----
// ddpf_pkg: shared types, codes and constant tables of the path follower
// no dependencies; used by the interfaces, the top level and the checker

package ddpf_pkg;

    localparam int POS_W  = 18;
    localparam int HD_W   = 15;
    localparam int LIN_W  = 13;
    localparam int ANG_W  = 14;
    localparam int IDX_W  = 8;
    localparam int OP_W   = 2;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 17;
    localparam int DIST_W = 18;

    // input operation codes
    localparam logic [OP_W-1:0] OP_BEGIN = 2'd0;
    localparam logic [OP_W-1:0] OP_POINT = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_MAX_LIN   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_MAX_ANG   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_GAUSS     = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_SIGMOID   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_LOOKAHEAD = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_REPLAN    = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_ARRIVE    = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_FINAL     = 3'd7;

    localparam logic [12:0] RST_MAX_LIN   = 13'd2048;
    localparam logic [12:0] RST_MAX_ANG   = 13'd2048;
    localparam logic [15:0] RST_GAUSS     = 16'd2682;
    localparam logic [11:0] RST_SIGMOID   = 12'd41;
    localparam logic [16:0] RST_LOOKAHEAD = 17'd819;
    localparam logic [16:0] RST_REPLAN    = 17'd3277;
    localparam logic [16:0] RST_ARRIVE    = 17'd410;
    localparam logic [16:0] RST_FINAL     = 17'd901;

    localparam logic [DIST_W-1:0] DIST_ONE_M = 18'd4096;
    localparam logic [DIST_W-1:0] DIST_MAX   = 18'h3FFFF;

    localparam logic signed [16:0] PI_Q12      = 17'sd12868;
    localparam logic signed [16:0] TWO_PI_Q12  = 17'sd25736;
    localparam logic signed [15:0] HALF_PI_Q12 = 16'sd6434;

    localparam logic [3:0] CORDIC_LAST = 4'd12;
    localparam logic [5:0] DIV_LAST    = 6'd35;
    localparam logic [3:0] SERIES_TOP  = 4'd8;

    typedef enum logic [5:0] {
        S_IDLE, S_LA, S_LAQ, S_WCHK, S_WDAT, S_WSQX, S_WSQY, S_WCMP,
        S_FRD, S_FDAT, S_ERR, S_CINIT, S_CITER, S_EWRAP,
        S_SQA, S_SQB, S_SQC, S_SQI,
        S_LMUL, S_LDIV, S_DIV, S_EXP0, S_EXM, S_EXV, S_EXU, S_EXT, S_EXR,
        S_LVM, S_LRES, S_ADIV, S_AMUL, S_AQ, S_AFIN, S_EMIT
    } t_state;

    // rounded atan(2^-i) in 1/4096 rad
    function automatic logic [15:0] atan_lut(input logic [3:0] i);
        logic [15:0] v;
        case (i)
            4'd0:    v = 16'd3217;
            4'd1:    v = 16'd1899;
            4'd2:    v = 16'd1003;
            4'd3:    v = 16'd509;
            4'd4:    v = 16'd256;
            4'd5:    v = 16'd128;
            4'd6:    v = 16'd64;
            4'd7:    v = 16'd32;
            4'd8:    v = 16'd16;
            4'd9:    v = 16'd8;
            4'd10:   v = 16'd4;
            4'd11:   v = 16'd2;
            4'd12:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // rounded exp(-n) in Q16
    function automatic logic [16:0] expn_lut(input logic [3:0] n);
        logic [16:0] v;
        case (n)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [18:0] abs19(input logic signed [18:0] x);
        return x[18] ? 19'(-x) : 19'(x);
    endfunction

endpackage

// ----- hw/rtl/ddpf_in_if.sv -----
// ddpf_in_if: input channel of the path follower (op, position, heading, mark)
// depends on ddpf_pkg

interface ddpf_in_if import ddpf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [HD_W-1:0]  heading;
    logic                    last_point;

    modport source (output valid, op, pos_x, pos_y, heading, last_point, input ready);
    modport sink   (input valid, op, pos_x, pos_y, heading, last_point, output ready);
endinterface

// ----- hw/rtl/ddpf_out_if.sv -----
// ddpf_out_if: result channel of the path follower (speed commands, status)
// depends on ddpf_pkg

interface ddpf_out_if import ddpf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [LIN_W-1:0]        linear_speed;
    logic signed [ANG_W-1:0] angular_speed;
    logic                    following;
    logic [IDX_W-1:0]        target_index;

    modport source (output valid, linear_speed, angular_speed, following, target_index,
                    input ready);
    modport sink   (input valid, linear_speed, angular_speed, following, target_index,
                    output ready);
endinterface

// ----- hw/rtl/ddpf_cfg_if.sv -----
// ddpf_cfg_if: configuration write channel (register index and data)
// depends on ddpf_pkg

interface ddpf_cfg_if import ddpf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CFG_AW-1:0] index;
    logic [CFG_DW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/ddpf_ram.sv -----
// ddpf_ram: generic single write port, single read port ram with registered read
// no dependencies

module ddpf_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/diff_drive_path_follower.sv -----
// diff_drive_path_follower: lookahead path follower for a differential drive robot
// depends on ddpf_pkg, ddpf_in_if, ddpf_out_if, ddpf_cfg_if, ddpf_ram
//
//  channel   dir  beat payload                                  handshake
//  i_in      in   op, pos_x, pos_y, heading, last_point        valid/ready
//  o_out     out  linear_speed, angular_speed, following, idx   valid/ready
//  i_cfg     in   index, data                                   valid/ready (always ready)
//
// begin and path point beats leave the block idle; ready stays high
// a pose tick while following walks the path points to the lookahead target, then makes
// up to nineteen runs of the shared divider, two 20-step square roots, 13 cordic steps
// reset (i_rst_n low, synchronous) clears the route and loads the register defaults
// the result sits in an output register; a stalled o_out holds the next tick at its end

module diff_drive_path_follower import ddpf_pkg::*; #(
    parameter int PATH_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ddpf_in_if.sink     i_in,
    ddpf_out_if.source  o_out,
    ddpf_cfg_if.sink    i_cfg
);
    localparam int AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
    localparam int CW = $clog2(PATH_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(PATH_DEPTH);

    t_state r_state, n_state, r_ret, n_ret;

    // configuration
    logic [12:0] r_max_lin, n_max_lin, r_max_ang, n_max_ang;
    logic [15:0] r_gauss, n_gauss;
    logic [11:0] r_sigmoid, n_sigmoid;
    logic [16:0] r_lookahead, n_lookahead, r_replan, n_replan;
    logic [16:0] r_arrive, n_arrive, r_final, n_final;

    // route state
    logic [CW-1:0]           r_count, n_count;
    logic                    r_active, n_active;
    logic [AW-1:0]           r_walk, n_walk;
    logic signed [POS_W-1:0] r_tgt_x, n_tgt_x, r_tgt_y, n_tgt_y;
    logic signed [POS_W-1:0] r_goal_x, n_goal_x, r_goal_y, n_goal_y;
    logic [DIST_W-1:0]       r_td, n_td, r_gd, n_gd;

    // working registers
    logic signed [POS_W-1:0] r_px, n_px, r_py, n_py, r_wpx, n_wpx, r_wpy, n_wpy;
    logic signed [HD_W-1:0]  r_hd, n_hd;
    logic signed [18:0]      r_ex, n_ex, r_ey, n_ey, r_gx, n_gx, r_gy, n_gy;
    logic signed [18:0]      r_dx, n_dx, r_dy, n_dy;
    logic [39:0]             r_acc, n_acc, r_la2, n_la2, r_prod;
    logic [CW-1:0]           r_i, n_i;
    logic signed [31:0]      r_cx, n_cx, r_cy, n_cy;
    logic signed [15:0]      r_cz, n_cz;
    logic [3:0]              r_k, n_k;
    logic                    r_eneg, n_eneg;
    logic [15:0]             r_mag, n_mag;
    logic [39:0]             r_sv, n_sv, r_sr, n_sr, r_sbit, n_sbit;
    logic                    r_sel, n_sel;
    logic [35:0]             r_quo, n_quo;
    logic [18:0]             r_rem, n_rem, r_dvs, n_dvs;
    logic [5:0]              r_dcnt, n_dcnt;
    logic [15:0]             r_f, n_f;
    logic [16:0]             r_er, n_er, r_expv, n_expv;
    logic [3:0]              r_kk, n_kk, r_n, n_n;
    logic                    r_phase, n_phase;
    logic [LIN_W-1:0]        r_lin, n_lin;
    logic signed [ANG_W-1:0] r_ang, n_ang;

    // output register
    logic                    r_ov, n_ov, r_o_fol, n_o_fol;
    logic [LIN_W-1:0]        r_o_lin, n_o_lin;
    logic signed [ANG_W-1:0] r_o_ang, n_o_ang;
    logic [IDX_W-1:0]        r_o_idx, n_o_idx;

    // ram
    logic                  w_we;
    logic [AW-1:0]         w_waddr, w_raddr;
    logic [2*POS_W-1:0]    w_wdata, w_rdata;
    logic signed [POS_W-1:0] w_rx, w_ry;

    // shared multiplier
    logic [19:0] w_mul_a, w_mul_b;

    logic w_in_acc, w_far, w_replan, w_final, w_i_in, w_wfound, w_czero, w_big, w_out_free;
    logic [39:0]        w_wsum;
    logic signed [31:0] w_x0, w_y0, w_sx, w_sy;
    logic signed [16:0] w_e1, w_e2, w_e3;
    logic [39:0]        w_st, w_sr_nx;
    logic               w_sge;
    logic [DIST_W-1:0]  w_sat;
    logic [19:0]        w_rsh, w_rsub;
    logic               w_dge;
    logic [15:0]        w_g;
    logic [11:0]        w_s;
    logic [17:0]        w_tsum;

    ddpf_ram #(.WIDTH(2*POS_W), .DEPTH(PATH_DEPTH)) u_path_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rx = w_rdata[2*POS_W-1:POS_W];
    assign w_ry = w_rdata[POS_W-1:0];

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid && (r_state == S_IDLE);
    assign w_out_free  = !r_ov || o_out.ready;

    assign o_out.valid         = r_ov;
    assign o_out.linear_speed  = r_o_lin;
    assign o_out.angular_speed = r_o_ang;
    assign o_out.following     = r_o_fol;
    assign o_out.target_index  = r_o_idx;

    assign w_far    = r_gd > DIST_W'(r_arrive);
    assign w_replan = r_td <= DIST_W'(r_replan);
    assign w_final  = (r_gd <= DIST_W'(r_final)) && (r_count != '0);
    assign w_i_in   = r_i < r_count;
    assign w_wsum   = r_acc + r_prod;
    assign w_wfound = w_wsum >= r_la2;

    assign w_we    = w_in_acc && (i_in.op == OP_POINT) && (r_count < DEPTH_C);
    assign w_waddr = AW'(r_count);
    assign w_wdata = {i_in.pos_x, i_in.pos_y};
    assign w_raddr = (r_state == S_FRD) ? AW'(r_count - 1'b1) : AW'(r_i);

    // cordic
    assign w_czero = (r_ex == '0) && (r_ey == '0);
    assign w_x0    = 32'(r_ex) <<< 10;
    assign w_y0    = 32'(r_ey) <<< 10;
    assign w_sx    = r_cy >>> r_k;
    assign w_sy    = r_cx >>> r_k;

    // heading error, wrapped once
    assign w_e1 = 17'(r_cz) - 17'(r_hd);
    assign w_e2 = (w_e1 > PI_Q12) ? w_e1 - TWO_PI_Q12 : w_e1;
    assign w_e3 = (w_e2 < -PI_Q12) ? w_e2 + TWO_PI_Q12 : w_e2;

    // square root step
    assign w_st    = r_sr + r_sbit;
    assign w_sge   = r_sv >= w_st;
    assign w_sr_nx = w_sge ? (r_sr >> 1) + r_sbit : r_sr >> 1;
    assign w_sat   = (w_sr_nx > 40'(DIST_MAX)) ? DIST_MAX : DIST_W'(w_sr_nx);

    // restoring divider step
    assign w_rsh  = {r_rem, r_quo[35]};
    assign w_dge  = w_rsh >= {1'b0, r_dvs};
    assign w_rsub = w_rsh - {1'b0, r_dvs};

    assign w_g    = (r_gauss == '0) ? 16'd1 : r_gauss;
    assign w_s    = (r_sigmoid == '0) ? 12'd1 : r_sigmoid;
    assign w_big  = r_quo[35:16] >= 20'd12;
    assign w_tsum = 18'd65536 + 18'(r_expv);

    always_comb begin
        case (r_state)
            S_LA:    begin w_mul_a = 20'(r_lookahead); w_mul_b = 20'(r_lookahead); end
            S_WSQX:  begin w_mul_a = 20'(abs19(r_dx)); w_mul_b = 20'(abs19(r_dx)); end
            S_WSQY:  begin w_mul_a = 20'(abs19(r_dy)); w_mul_b = 20'(abs19(r_dy)); end
            S_SQA:   begin
                w_mul_a = 20'(abs19(r_sel ? r_gx : r_ex));
                w_mul_b = 20'(abs19(r_sel ? r_gx : r_ex));
            end
            S_SQB:   begin
                w_mul_a = 20'(abs19(r_sel ? r_gy : r_ey));
                w_mul_b = 20'(abs19(r_sel ? r_gy : r_ey));
            end
            S_LMUL:  begin w_mul_a = 20'(r_mag);           w_mul_b = 20'(r_mag);  end
            S_EXM:   begin w_mul_a = 20'(r_f);             w_mul_b = 20'(r_er);   end
            S_EXT:   begin w_mul_a = 20'(expn_lut(r_n));   w_mul_b = 20'(r_er);   end
            S_LVM:   begin w_mul_a = 20'(r_max_lin);       w_mul_b = 20'(r_expv); end
            S_AMUL:  begin
                w_mul_a = 20'(r_max_ang);
                w_mul_b = 20'(18'd65536 - 18'(r_expv));
            end
            default: begin w_mul_a = '0; w_mul_b = '0; end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_in.op == OP_TICK)) begin
                    if (!r_active || !w_far) begin
                        n_state = S_EMIT;
                    end else if (w_replan) begin
                        n_state = S_LA;
                    end else if (w_final) begin
                        n_state = S_FRD;
                    end else begin
                        n_state = S_ERR;
                    end
                end
            end
            S_LA:    n_state = S_LAQ;
            S_LAQ:   n_state = S_WCHK;
            S_WCHK:  n_state = w_i_in ? S_WDAT : S_ERR;
            S_WDAT:  n_state = S_WSQX;
            S_WSQX:  n_state = S_WSQY;
            S_WSQY:  n_state = S_WCMP;
            S_WCMP:  n_state = w_wfound ? S_ERR : S_WCHK;
            S_FRD:   n_state = S_FDAT;
            S_FDAT:  n_state = S_ERR;
            S_ERR:   n_state = S_CINIT;
            S_CINIT: n_state = w_czero ? S_EWRAP : S_CITER;
            S_CITER: n_state = (r_k == CORDIC_LAST) ? S_EWRAP : S_CITER;
            S_EWRAP: n_state = S_SQA;
            S_SQA:   n_state = S_SQB;
            S_SQB:   n_state = S_SQC;
            S_SQC:   n_state = S_SQI;
            S_SQI: begin
                if (r_sbit[0]) begin
                    n_state = r_sel ? S_LMUL : S_SQA;
                end
            end
            S_LMUL:  n_state = S_LDIV;
            S_LDIV:  n_state = S_DIV;
            S_DIV:   n_state = (r_dcnt == DIV_LAST) ? r_ret : S_DIV;
            S_EXP0: begin
                if (w_big) begin
                    n_state = r_phase ? S_AMUL : S_LVM;
                end else begin
                    n_state = S_EXM;
                end
            end
            S_EXM:   n_state = S_EXV;
            S_EXV:   n_state = S_DIV;
            S_EXU:   n_state = (r_kk == 4'd1) ? S_EXT : S_EXM;
            S_EXT:   n_state = S_EXR;
            S_EXR:   n_state = r_phase ? S_AMUL : S_LVM;
            S_LVM:   n_state = S_LRES;
            S_LRES:  n_state = S_ADIV;
            S_ADIV:  n_state = S_DIV;
            S_AMUL:  n_state = S_AQ;
            S_AQ:    n_state = S_DIV;
            S_AFIN:  n_state = S_EMIT;
            S_EMIT:  n_state = w_out_free ? S_IDLE : S_EMIT;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and register updates
    always_comb begin
        n_ret = r_ret;
        n_max_lin = r_max_lin; n_max_ang = r_max_ang; n_gauss = r_gauss;
        n_sigmoid = r_sigmoid; n_lookahead = r_lookahead; n_replan = r_replan;
        n_arrive = r_arrive; n_final = r_final;
        n_count = r_count; n_active = r_active; n_walk = r_walk;
        n_tgt_x = r_tgt_x; n_tgt_y = r_tgt_y; n_goal_x = r_goal_x; n_goal_y = r_goal_y;
        n_td = r_td; n_gd = r_gd;
        n_px = r_px; n_py = r_py; n_hd = r_hd; n_wpx = r_wpx; n_wpy = r_wpy;
        n_ex = r_ex; n_ey = r_ey; n_gx = r_gx; n_gy = r_gy; n_dx = r_dx; n_dy = r_dy;
        n_acc = r_acc; n_la2 = r_la2; n_i = r_i;
        n_cx = r_cx; n_cy = r_cy; n_cz = r_cz; n_k = r_k;
        n_eneg = r_eneg; n_mag = r_mag;
        n_sv = r_sv; n_sr = r_sr; n_sbit = r_sbit; n_sel = r_sel;
        n_quo = r_quo; n_rem = r_rem; n_dvs = r_dvs; n_dcnt = r_dcnt;
        n_f = r_f; n_er = r_er; n_kk = r_kk; n_n = r_n; n_expv = r_expv; n_phase = r_phase;
        n_lin = r_lin; n_ang = r_ang;
        n_ov = r_ov && !o_out.ready;
        n_o_lin = r_o_lin; n_o_ang = r_o_ang; n_o_fol = r_o_fol; n_o_idx = r_o_idx;

        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_MAX_LIN:   n_max_lin   = i_cfg.data[12:0];
                CFG_MAX_ANG:   n_max_ang   = i_cfg.data[12:0];
                CFG_GAUSS:     n_gauss     = i_cfg.data[15:0];
                CFG_SIGMOID:   n_sigmoid   = i_cfg.data[11:0];
                CFG_LOOKAHEAD: n_lookahead = i_cfg.data;
                CFG_REPLAN:    n_replan    = i_cfg.data;
                CFG_ARRIVE:    n_arrive    = i_cfg.data;
                CFG_FINAL:     n_final     = i_cfg.data;
                default:       ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_px = i_in.pos_x;
                    n_py = i_in.pos_y;
                    n_hd = i_in.heading;
                    case (i_in.op)
                        OP_BEGIN: begin
                            n_goal_x = i_in.pos_x;
                            n_goal_y = i_in.pos_y;
                            n_tgt_x  = i_in.pos_x;
                            n_tgt_y  = i_in.pos_y;
                            n_count  = '0;
                            n_active = 1'b0;
                            n_walk   = '0;
                            n_td     = '0;
                            n_gd     = DIST_ONE_M;
                        end
                        OP_POINT: begin
                            if (r_count < DEPTH_C) begin
                                n_count = r_count + 1'b1;
                            end
                            if (i_in.last_point) begin
                                n_active = 1'b1;
                            end
                        end
                        OP_TICK: begin
                            n_lin = '0;
                            n_ang = '0;
                            // arrival ends the route
                            if (r_active && !w_far) begin
                                n_active = 1'b0;
                                n_walk   = '0;
                                n_td     = '0;
                                n_gd     = DIST_ONE_M;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LAQ: begin
                n_la2 = r_prod;
                n_i   = CW'(r_walk);
            end
            S_WDAT: begin
                n_wpx = w_rx;
                n_wpy = w_ry;
                n_dx  = 19'(w_rx) - 19'(r_px);
                n_dy  = 19'(w_ry) - 19'(r_py);
            end
            S_WSQY: n_acc = r_prod;
            S_WCMP: begin
                if (w_wfound) begin
                    n_tgt_x = r_wpx;
                    n_tgt_y = r_wpy;
                    n_walk  = AW'(r_i);
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_FDAT: begin
                n_tgt_x = w_rx;
                n_tgt_y = w_ry;
            end
            S_ERR: begin
                n_ex = 19'(r_tgt_x) - 19'(r_px);
                n_ey = 19'(r_tgt_y) - 19'(r_py);
                n_gx = 19'(r_goal_x) - 19'(r_px);
                n_gy = 19'(r_goal_y) - 19'(r_py);
            end
            S_CINIT: begin
                n_k  = '0;
                n_cx = w_x0;
                n_cy = w_y0;
                n_cz = '0;
                // pre-rotate the left half plane by a quarter turn
                if (!w_czero && w_x0 < 0) begin
                    if (w_y0 >= 0) begin
                        n_cx = w_y0;
                        n_cy = -w_x0;
                        n_cz = HALF_PI_Q12;
                    end else begin
                        n_cx = -w_y0;
                        n_cy = w_x0;
                        n_cz = -HALF_PI_Q12;
                    end
                end
            end
            S_CITER: begin
                n_k = r_k + 1'b1;
                if (r_cy > 0) begin
                    n_cx = r_cx + w_sx;
                    n_cy = r_cy - w_sy;
                    n_cz = r_cz + $signed(atan_lut(r_k));
                end else begin
                    n_cx = r_cx - w_sx;
                    n_cy = r_cy + w_sy;
                    n_cz = r_cz - $signed(atan_lut(r_k));
                end
            end
            S_EWRAP: begin
                n_eneg = w_e3[16];
                n_mag  = w_e3[16] ? 16'(-w_e3) : 16'(w_e3);
                n_sel  = 1'b0;
            end
            S_SQB: n_acc = r_prod;
            S_SQC: begin
                n_sv   = r_acc + r_prod;
                n_sr   = '0;
                n_sbit = 40'd1 << 38;
            end
            S_SQI: begin
                n_sv   = w_sge ? r_sv - w_st : r_sv;
                n_sr   = w_sr_nx;
                n_sbit = r_sbit >> 2;
                if (r_sbit[0]) begin
                    if (r_sel) begin
                        n_gd = w_sat;
                    end else begin
                        n_td  = w_sat;
                        n_sel = 1'b1;
                    end
                end
            end
            S_LMUL: n_phase = 1'b0;
            S_LDIV: begin
                n_quo  = 36'(r_prod) << 4;
                n_rem  = '0;
                n_dvs  = 19'(w_g);
                n_dcnt = '0;
                n_ret  = S_EXP0;
            end
            S_DIV: begin
                n_rem  = w_dge ? w_rsub[18:0] : w_rsh[18:0];
                n_quo  = {r_quo[34:0], w_dge};
                n_dcnt = r_dcnt + 1'b1;
            end
            S_EXP0: begin
                if (w_big) begin
                    n_expv = '0;
                end else begin
                    n_f  = r_quo[15:0];
                    n_n  = r_quo[19:16];
                    n_er = 17'd65536;
                    n_kk = SERIES_TOP;
                end
            end
            S_EXV: begin
                n_quo  = 36'(r_prod[39:16]);
                n_rem  = '0;
                n_dvs  = 19'(r_kk);
                n_dcnt = '0;
                n_ret  = S_EXU;
            end
            S_EXU: begin
                n_er = 17'(18'd65536 - 18'(r_quo[16:0]));
                n_kk = r_kk - 1'b1;
            end
            S_EXR:  n_expv = 17'((r_prod + 40'd32768) >> 16);
            S_LRES: begin
                n_lin   = LIN_W'((r_prod + 40'd32768) >> 16);
                n_phase = 1'b1;
            end
            S_ADIV: begin
                n_quo  = 36'({r_mag, 16'd0});
                n_rem  = '0;
                n_dvs  = 19'(w_s);
                n_dcnt = '0;
                n_ret  = S_EXP0;
            end
            S_AQ: begin
                // rounded wmax*(1-t)/(1+t)
                n_quo  = (36'(r_prod) << 1) + 36'(w_tsum);
                n_rem  = '0;
                n_dvs  = {w_tsum, 1'b0};
                n_dcnt = '0;
                n_ret  = S_AFIN;
            end
            S_AFIN: n_ang = r_eneg ? -ANG_W'(r_quo) : ANG_W'(r_quo);
            S_EMIT: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_o_lin = r_lin;
                    n_o_ang = r_ang;
                    n_o_fol = r_active;
                    n_o_idx = IDX_W'(r_walk);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_lin   <= RST_MAX_LIN;
            r_max_ang   <= RST_MAX_ANG;
            r_gauss     <= RST_GAUSS;
            r_sigmoid   <= RST_SIGMOID;
            r_lookahead <= RST_LOOKAHEAD;
            r_replan    <= RST_REPLAN;
            r_arrive    <= RST_ARRIVE;
            r_final     <= RST_FINAL;
            r_count     <= '0;
            r_active    <= 1'b0;
            r_walk      <= '0;
            r_tgt_x     <= '0;
            r_tgt_y     <= '0;
            r_goal_x    <= '0;
            r_goal_y    <= '0;
            r_td        <= '0;
            r_gd        <= DIST_ONE_M;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_max_lin   <= n_max_lin;
            r_max_ang   <= n_max_ang;
            r_gauss     <= n_gauss;
            r_sigmoid   <= n_sigmoid;
            r_lookahead <= n_lookahead;
            r_replan    <= n_replan;
            r_arrive    <= n_arrive;
            r_final     <= n_final;
            r_count     <= n_count;
            r_active    <= n_active;
            r_walk      <= n_walk;
            r_tgt_x     <= n_tgt_x;
            r_tgt_y     <= n_tgt_y;
            r_goal_x    <= n_goal_x;
            r_goal_y    <= n_goal_y;
            r_td        <= n_td;
            r_gd        <= n_gd;
            r_ov        <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret <= n_ret;
        r_prod <= 40'(w_mul_a) * 40'(w_mul_b);
        r_px <= n_px; r_py <= n_py; r_hd <= n_hd; r_wpx <= n_wpx; r_wpy <= n_wpy;
        r_ex <= n_ex; r_ey <= n_ey; r_gx <= n_gx; r_gy <= n_gy;
        r_dx <= n_dx; r_dy <= n_dy;
        r_acc <= n_acc; r_la2 <= n_la2; r_i <= n_i;
        r_cx <= n_cx; r_cy <= n_cy; r_cz <= n_cz; r_k <= n_k;
        r_eneg <= n_eneg; r_mag <= n_mag;
        r_sv <= n_sv; r_sr <= n_sr; r_sbit <= n_sbit; r_sel <= n_sel;
        r_quo <= n_quo; r_rem <= n_rem; r_dvs <= n_dvs; r_dcnt <= n_dcnt;
        r_f <= n_f; r_er <= n_er; r_kk <= n_kk; r_n <= n_n;
        r_expv <= n_expv; r_phase <= n_phase;
        r_lin <= n_lin; r_ang <= n_ang;
        r_o_lin <= n_o_lin; r_o_ang <= n_o_ang; r_o_fol <= n_o_fol; r_o_idx <= n_o_idx;
    end

endmodule

// ----- hw/rtl/ddpf_checker.sv -----
// ddpf_checker: port-level assertions for the path follower, bound to the top level
// depends on ddpf_pkg and diff_drive_path_follower

module ddpf_checker import ddpf_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic [OP_W-1:0]         i_in_op,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [LIN_W-1:0]        i_out_lin,
    input logic signed [ANG_W-1:0] i_out_ang,
    input logic                    i_out_fol
);
    // a pose tick always drops input ready in the cycle after its beat
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_op == OP_TICK) |=> !i_in_ready)
        else $error("input still ready after a pose tick beat");

    // after a begin beat the input is ready again in the next cycle
    a_begin_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_op == OP_BEGIN) |=> i_in_ready)
        else $error("input not ready after a begin beat");

    // not following means the robot is stopped
    a_stop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_fol) |-> (i_out_lin == '0 && i_out_ang == '0))
        else $error("nonzero speed while not following");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_lin) && $stable(i_out_ang)))
        else $error("stalled result beat changed");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");
endmodule

bind diff_drive_path_follower ddpf_checker u_ddpf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.op),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_lin   (o_out.linear_speed),
    .i_out_ang   (o_out.angular_speed),
    .i_out_fol   (o_out.following)
);
